FILE: src/xrs_pkg.sv
// Package for the xoroshiro128+ generator core.
// Holds request and register codes, command and state types, and the state-step functions.
// No dependencies.
package xrs_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned SeedW = 32;
  localparam int unsigned CntW  = 16;
  localparam int unsigned StepW = 7;

  localparam logic [ReqW-1:0] REQ_DRAW      = 3'd0;
  localparam logic [ReqW-1:0] REQ_JUMP      = 3'd1;
  localparam logic [ReqW-1:0] REQ_LONG_JUMP = 3'd2;
  localparam logic [ReqW-1:0] REQ_RESEED    = 3'd3;
  localparam logic [ReqW-1:0] REQ_LOAD      = 3'd4;

  localparam logic [IdxW-1:0] CFG_SEED        = 3'd0;
  localparam logic [IdxW-1:0] CFG_SCRUB       = 3'd1;
  localparam logic [IdxW-1:0] CFG_JUMP_LO     = 3'd2;
  localparam logic [IdxW-1:0] CFG_JUMP_HI     = 3'd3;
  localparam logic [IdxW-1:0] CFG_LONG_JUMP_LO = 3'd4;
  localparam logic [IdxW-1:0] CFG_LONG_JUMP_HI = 3'd5;

  localparam logic [StepW-1:0] LAST_STEP = 7'd127;

  typedef enum logic [2:0] {
    OP_DRAW,
    OP_JUMP,
    OP_LONG_JUMP,
    OP_RESEED,
    OP_LOAD,
    OP_HOLD
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAP,
    ST_SCRUB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [WordW-1:0] load_x;
    logic [WordW-1:0] load_y;
  } cmd_t;

  typedef struct packed {
    logic [SeedW-1:0] seed;
    logic [CntW-1:0]  scrub;
    logic [WordW-1:0] jump_lo;
    logic [WordW-1:0] jump_hi;
    logic [WordW-1:0] long_jump_lo;
    logic [WordW-1:0] long_jump_hi;
  } cfg_t;

  typedef struct packed {
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
  } xy_t;

  // One xoroshiro128+ step, rotations 24 and 37, shift 16.
  function automatic xy_t xr_advance(xy_t s);
    logic [WordW-1:0] b;
    xy_t r;
    b   = s.y ^ s.x;
    r.x = {s.x[39:0], s.x[63:40]} ^ b ^ {b[47:0], 16'h0000};
    r.y = {b[26:0], b[63:27]};
    return r;
  endfunction

  // Seed bits to even bits of x and odd bits of y.
  function automatic xy_t xr_spread(logic [SeedW-1:0] seed);
    xy_t r;
    r = '0;
    for (int i = 0; i < SeedW; i++) begin
      r.x[2*i]   = seed[i];
      r.y[2*i+1] = seed[i];
    end
    return r;
  endfunction

endpackage

FILE: src/xrs_req_if.sv
// Request channel interface: valid/ready plus request payload.
// Depends on xrs_pkg.
interface xrs_req_if
  import xrs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [WordW-1:0] load_word_x;
  logic [WordW-1:0] load_word_y;

  modport source (output valid, req_type, load_word_x, load_word_y, input ready);
  modport sink   (input valid, req_type, load_word_x, load_word_y, output ready);
endinterface

FILE: src/xrs_rsp_if.sv
// Result channel interface: valid/ready plus result payload.
// Depends on xrs_pkg.
interface xrs_rsp_if
  import xrs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] random_value;
  logic [WordW-1:0] state_word_x;
  logic [WordW-1:0] state_word_y;

  modport source (output valid, random_value, state_word_x, state_word_y, input ready);
  modport sink   (input valid, random_value, state_word_x, state_word_y, output ready);
endinterface

FILE: src/xrs_cfg_if.sv
// Configuration write channel interface: valid/ready, register index and data.
// Depends on xrs_pkg.
interface xrs_cfg_if
  import xrs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [WordW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/xrs_front.sv
// Front end: takes request transfers, decodes them into commands, two-entry queue.
// Depends on xrs_pkg and xrs_req_if.
module xrs_front
  import xrs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  xrs_req_if.sink req,
  output logic   cmd_valid,
  output cmd_t   cmd,
  input  logic   cmd_pop
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;
  cmd_t       dec;

  always_comb begin
    dec.load_x = req.load_word_x;
    dec.load_y = req.load_word_y;
    case (req.req_type)
      REQ_DRAW:      dec.op = OP_DRAW;
      REQ_JUMP:      dec.op = OP_JUMP;
      REQ_LONG_JUMP: dec.op = OP_LONG_JUMP;
      REQ_RESEED:    dec.op = OP_RESEED;
      REQ_LOAD:      dec.op = OP_LOAD;
      default:       dec.op = OP_HOLD;
    endcase
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !cmd_pop) begin
      count_next = count + 2'd1;
    end else if (!push && cmd_pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= dec;
    end
  end

endmodule

FILE: src/xrs_back.sv
// Back end: holds generator state, runs draws, jumps, reseed scrubbing and loads.
// Drives the registered result channel. Depends on xrs_pkg and xrs_rsp_if.
module xrs_back
  import xrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  cfg_t      cfg,
  xrs_rsp_if.source rsp
);

  state_t           state;
  state_t           state_next;
  xy_t              gen;
  xy_t              acc;
  xy_t              adv;
  xy_t              res_xy;
  logic [CntW-1:0]  cnt;
  logic             use_long;
  logic [2*WordW-1:0] poly;
  logic             pbit;
  logic             slot_free;
  logic             long_op;
  logic             emit;
  logic [WordW-1:0] sum_a;
  logic [WordW-1:0] sum_b;

  logic             out_valid;
  logic [WordW-1:0] out_value;
  logic [WordW-1:0] out_x;
  logic [WordW-1:0] out_y;

  assign adv       = xr_advance(gen);
  assign poly      = use_long ? {cfg.long_jump_hi, cfg.long_jump_lo}
                              : {cfg.jump_hi, cfg.jump_lo};
  assign pbit      = poly[cnt[StepW-1:0]];
  assign slot_free = !out_valid || rsp.ready;
  assign long_op   = (cmd.op == OP_JUMP) || (cmd.op == OP_LONG_JUMP) ||
                     (cmd.op == OP_RESEED);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_JUMP, OP_LONG_JUMP: state_next = ST_LEAP;
            OP_RESEED: state_next = (cfg.scrub == '0) ? ST_EMIT : ST_SCRUB;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_LEAP: begin
        if (cnt[StepW-1:0] == LAST_STEP) begin
          state_next = ST_EMIT;
        end
      end
      ST_SCRUB: begin
        if (cnt == CntW'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    emit    = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_pop = cmd_valid && (long_op || slot_free);
        emit    = cmd_valid && !long_op && slot_free;
      end
      ST_EMIT: emit = slot_free;
      default: begin
        cmd_pop = 1'b0;
        emit    = 1'b0;
      end
    endcase
  end

  // Result operands: direct commands report from IDLE, long ones from EMIT.
  always_comb begin
    sum_a  = gen.x;
    sum_b  = gen.y;
    res_xy = gen;
    if (state == ST_IDLE) begin
      case (cmd.op)
        OP_DRAW: res_xy = adv;
        OP_LOAD: begin
          sum_a    = cmd.load_x;
          sum_b    = cmd.load_y;
          res_xy.x = cmd.load_x;
          res_xy.y = cmd.load_y;
        end
        default: res_xy = gen;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              OP_DRAW: gen <= adv;
              OP_JUMP, OP_LONG_JUMP: begin
                acc      <= '0;
                cnt      <= '0;
                use_long <= (cmd.op == OP_LONG_JUMP);
              end
              OP_RESEED: begin
                gen <= xr_spread(cfg.seed);
                cnt <= cfg.scrub;
              end
              OP_LOAD: begin
                gen.x <= cmd.load_x;
                gen.y <= cmd.load_y;
              end
              default: gen <= gen;
            endcase
          end
        end
        ST_LEAP: begin
          if (pbit) begin
            acc <= acc ^ gen;
          end
          cnt <= cnt + CntW'(1);
          if (cnt[StepW-1:0] == LAST_STEP) begin
            gen <= pbit ? (acc ^ gen) : acc;
          end else begin
            gen <= adv;
          end
        end
        ST_SCRUB: begin
          gen <= adv;
          cnt <= cnt - CntW'(1);
        end
        default: gen <= gen;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value <= sum_a + sum_b;
      out_x     <= res_xy.x;
      out_y     <= res_xy.y;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_value;
  assign rsp.state_word_x = out_x;
  assign rsp.state_word_y = out_y;

endmodule

FILE: src/xoroshiro128_plus_generator_core.sv
// Draw, load and unknown requests are answered directly from the idle back end; draws
// stream at one per cycle while the result channel takes them. Jump and long jump run
// 128 state steps before their result. Reseed runs scrub_count state steps, one per
// cycle, before its result. Synchronous rst zeroes state, configuration and queue;
// no clearing pass. Top level: config registers, front and back.
// Depends on xrs_pkg, the channel interfaces, xrs_front and xrs_back.
module xoroshiro128_plus_generator_core
  import xrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  xrs_cfg_if.sink   cfg,
  xrs_req_if.sink   req,
  xrs_rsp_if.source rsp
);

  cfg_t cfg_regs;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SEED:         cfg_regs.seed         <= cfg.data[SeedW-1:0];
        CFG_SCRUB:        cfg_regs.scrub        <= cfg.data[CntW-1:0];
        CFG_JUMP_LO:      cfg_regs.jump_lo      <= cfg.data;
        CFG_JUMP_HI:      cfg_regs.jump_hi      <= cfg.data;
        CFG_LONG_JUMP_LO: cfg_regs.long_jump_lo <= cfg.data;
        CFG_LONG_JUMP_HI: cfg_regs.long_jump_hi <= cfg.data;
        default:          cfg_regs <= cfg_regs;
      endcase
    end
  end

  xrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  xrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg_regs),
    .rsp       (rsp)
  );

`ifndef SYNTH
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");

  a_full_has_cmd: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> cmd_valid)
    else $error("queue full but no command visible");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("result valid after reset");
`endif

endmodule

FILE: tb/sv/tb.sv
// Testbench for xoroshiro128_plus_generator_core: a directed table then random phases,
// every result checked against a behavioural predictor, or against the table for typed rows.
// Depends on xrs_pkg, xrs_req_if, xrs_rsp_if, xrs_cfg_if and the core.
module tb;
  import xrs_pkg::*;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t value;
    word_t x;
    word_t y;
  } gen_out_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] code;
    word_t      arg_x;
    word_t      arg_y;
    logic       typed;
    gen_out_t   want;
  } row_t;

  localparam logic [ReqW-1:0] REQ_BAD_LO  = 3'd5;
  localparam logic [ReqW-1:0] REQ_BAD_MID = 3'd6;
  localparam logic [ReqW-1:0] REQ_BAD_HI  = 3'd7;
  localparam logic [IdxW-1:0] CFG_NONE_A  = 3'd6;
  localparam logic [IdxW-1:0] CFG_NONE_B  = 3'd7;

  localparam word_t    ONES    = '1;
  localparam gen_out_t NIL_OUT = '0;

  localparam int NUM_ROWS      = 41;
  localparam int NUM_PHASES    = 14;
  localparam int PHASE_ITEMS   = 132;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PCT      = 11;

  logic clk;
  logic rst;

  xrs_cfg_if cfg_ch ();
  xrs_req_if req_ch ();
  xrs_rsp_if rsp_ch ();

  xoroshiro128_plus_generator_core dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state and configuration
  word_t             gen_x;
  word_t             gen_y;
  logic [SeedW-1:0]  seed_reg;
  logic [CntW-1:0]   scrub_reg;
  logic [127:0]      jump_poly;
  logic [127:0]      long_poly;

  gen_out_t results_due [$];
  int       mismatches;
  bit       quiet;

  row_t plan [NUM_ROWS] = '{
    '{ROW_REQ, REQ_DRAW,    '0, '0, 1'b1, NIL_OUT},
    '{ROW_REQ, REQ_JUMP,    '0, '0, 1'b1, NIL_OUT},
    '{ROW_REQ, REQ_BAD_HI,  '0, '0, 1'b1, NIL_OUT},
    '{ROW_REQ, REQ_LOAD, ONES, ONES, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFE, ONES, ONES}},
    '{ROW_REQ, REQ_DRAW,    '0, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_LOAD, 64'd1, 64'd0, 1'b1, '{64'd1, 64'd1, 64'd0}},
    '{ROW_REQ, REQ_DRAW,    '0, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_BAD_LO,  '0, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_BAD_MID, '0, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_JUMP,    '0, '0, 1'b1, NIL_OUT},
    '{ROW_REQ, REQ_LOAD, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1,
      '{ONES, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}},
    '{ROW_CFG, CFG_JUMP_LO,      64'hDF90_0294_D8F5_54A5, '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_JUMP_HI,      64'h1708_65DF_4B32_01FC, '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_LONG_JUMP_LO, 64'hD2A9_8B26_625E_EE7B, '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_LONG_JUMP_HI, 64'hDDDF_9B10_90AA_7AC1, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_JUMP,      '0, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_LONG_JUMP, '0, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_DRAW,      '0, '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_JUMP_LO, ONES, '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_JUMP_HI, ONES, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_JUMP,    '0,   '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_JUMP_LO, 64'd1, '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_JUMP_HI, 64'd0, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_JUMP,    '0,    '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_SEED, 64'h0000_0000_7FFF_FFFF, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_RESEED, '0, '0, 1'b1,
      '{64'h3FFF_FFFF_FFFF_FFFF, 64'h1555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA}},
    '{ROW_CFG, CFG_SEED, 64'hA5A5_A5A5_8000_0000, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_RESEED, '0, '0, 1'b1,
      '{64'hC000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000}},
    '{ROW_CFG, CFG_SEED, 64'h5A5A_5A5A_FFFF_FFFF, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_RESEED, '0, '0, 1'b1,
      '{ONES, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}},
    '{ROW_CFG, CFG_SCRUB,  ONES, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_RESEED, '0,   '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_SCRUB,   64'h1234_5678_9ABC_0001, '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_NONE_A,  ONES,                    '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_NONE_B,  64'h0F0F_0F0F_0F0F_0F0F, '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_JUMP_LO, 64'd0,                   '0, 1'b0, NIL_OUT},
    '{ROW_CFG, CFG_JUMP_HI, 64'h8000_0000_0000_0000, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_RESEED, '0, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_JUMP,   '0, '0, 1'b0, NIL_OUT},
    '{ROW_REQ, REQ_LOAD,   '0, '0, 1'b1, NIL_OUT},
    '{ROW_REQ, REQ_DRAW,   '0, '0, 1'b1, NIL_OUT}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #15000000;
    $display("FAILURE");
    $finish;
  end

  function automatic word_t rot_left(word_t v, int k);
    return (v << k) | (v >> (WordW - k));
  endfunction

  function automatic void advance_state();
    word_t b;
    b     = gen_y ^ gen_x;
    gen_x = rot_left(gen_x, 24) ^ b ^ (b << 16);
    gen_y = rot_left(b, 37);
  endfunction

  function automatic void leap_state(logic [127:0] poly);
    word_t acc_x;
    word_t acc_y;
    acc_x = '0;
    acc_y = '0;
    for (int i = 0; i < 128; i++) begin
      if (poly[i]) begin
        acc_x ^= gen_x;
        acc_y ^= gen_y;
      end
      advance_state();
    end
    gen_x = acc_x;
    gen_y = acc_y;
  endfunction

  function automatic void reseed_state();
    gen_x = '0;
    gen_y = '0;
    for (int i = 0; i < SeedW; i++) begin
      gen_x[2*i]   = seed_reg[i];
      gen_y[2*i+1] = seed_reg[i];
    end
    for (int n = 0; n < scrub_reg; n++) advance_state();
  endfunction

  function automatic gen_out_t serve_request(logic [ReqW-1:0] code, word_t lx, word_t ly);
    gen_out_t o;
    o.value = gen_x + gen_y;
    case (code)
      REQ_DRAW:      advance_state();
      REQ_JUMP:      leap_state(jump_poly);
      REQ_LONG_JUMP: leap_state(long_poly);
      REQ_RESEED:    reseed_state();
      REQ_LOAD: begin
        gen_x = lx;
        gen_y = ly;
      end
      default: ;
    endcase
    if (code != REQ_DRAW) o.value = gen_x + gen_y;
    o.x = gen_x;
    o.y = gen_y;
    return o;
  endfunction

  function automatic void store_reg(logic [IdxW-1:0] idx, word_t v);
    case (idx)
      CFG_SEED:         seed_reg           = v[SeedW-1:0];
      CFG_SCRUB:        scrub_reg          = v[CntW-1:0];
      CFG_JUMP_LO:      jump_poly[63:0]    = v;
      CFG_JUMP_HI:      jump_poly[127:64]  = v;
      CFG_LONG_JUMP_LO: long_poly[63:0]    = v;
      CFG_LONG_JUMP_HI: long_poly[127:64]  = v;
      default: ;
    endcase
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return ONES;
      2:       return word_t'(1) << $urandom_range(0, WordW - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic word_t reg_value(logic [IdxW-1:0] idx);
    word_t v;
    v = {$urandom, $urandom};
    case (idx)
      CFG_SEED: begin
        case ($urandom_range(0, 4))
          0: v[31:0] = 32'h8000_0000;
          1: v[31:0] = 32'h7FFF_FFFF;
          2: v[31:0] = 32'hFFFF_FFFF;
          3: v[31:0] = 32'h0;
          default: ;
        endcase
      end
      // keep scrub passes short; the full count is covered once in the table
      CFG_SCRUB: v[15:0] = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 200));
      default: v = rand_word();
    endcase
    return v;
  endfunction

  function automatic void check_word(string what, word_t want, word_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  task automatic settle();
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves valid high on return; the caller lowers it when the group ends
  task automatic write_reg(logic [IdxW-1:0] idx, word_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    store_reg(idx, v);
  endtask

  task automatic send_req(logic [ReqW-1:0] code, word_t lx, word_t ly, bit typed,
                          gen_out_t want);
    gen_out_t calc;
    if (!quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= code;
    req_ch.load_word_x <= lx;
    req_ch.load_word_y <= ly;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    calc = serve_request(code, lx, ly);
    results_due.push_back(typed ? want : calc);
  endtask

  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else     rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : result_check
    gen_out_t due;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h %h %h", $time,
                 rsp_ch.random_value, rsp_ch.state_word_x, rsp_ch.state_word_y);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        check_word("random_value", due.value, rsp_ch.random_value);
        check_word("state_word_x", due.x, rsp_ch.state_word_x);
        check_word("state_word_y", due.y, rsp_ch.state_word_y);
      end
    end
  end

  initial begin : stimulus
    row_t            r;
    bit              in_cfg;
    logic [IdxW-1:0] ri;
    logic [ReqW-1:0] code;
    int              pick;

    rst                = 1'b1;
    quiet              = 1'b0;
    mismatches         = 0;
    in_cfg             = 1'b0;
    gen_x              = '0;
    gen_y              = '0;
    seed_reg           = '0;
    scrub_reg          = '0;
    jump_poly          = '0;
    long_poly          = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_DRAW;
    req_ch.load_word_x = '0;
    req_ch.load_word_y = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      r = plan[i];
      if (r.kind == ROW_CFG) begin
        if (!in_cfg) begin
          req_ch.valid <= 1'b0;
          settle();
          in_cfg = 1'b1;
        end
        write_reg(r.code, r.arg_x);
      end else begin
        if (in_cfg) begin
          cfg_ch.valid <= 1'b0;
          in_cfg = 1'b0;
        end
        send_req(r.code, r.arg_x, r.arg_y, r.typed, r.want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      req_ch.valid <= 1'b0;
      quiet = 1'b0;
      settle();
      for (ri = CFG_SEED; ri <= CFG_LONG_JUMP_HI; ri++) begin
        if (p == 0 || $urandom_range(0, 3) != 0) write_reg(ri, reg_value(ri));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_NONE_A : CFG_NONE_B, rand_word());
      cfg_ch.valid <= 1'b0;
      quiet = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 7 && n == PHASE_ITEMS / 2) begin
          req_ch.valid <= 1'b0;
          settle();
        end
        pick = $urandom_range(0, 99);
        if      (pick < 70) code = REQ_DRAW;
        else if (pick < 80) code = REQ_LOAD;
        else if (pick < 85) code = REQ_JUMP;
        else if (pick < 89) code = REQ_LONG_JUMP;
        else if (pick < 96) code = REQ_RESEED;
        else                code = ReqW'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        send_req(code, rand_word(), rand_word(), 1'b0, NIL_OUT);
      end
    end

    req_ch.valid <= 1'b0;
    quiet = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: xoroshiro128_plus_generator_core.f
src/xrs_pkg.sv
src/xrs_req_if.sv
src/xrs_rsp_if.sv
src/xrs_cfg_if.sv
src/xrs_front.sv
src/xrs_back.sv
src/xoroshiro128_plus_generator_core.sv
tb/sv/tb.sv
